@@ rtl/scc_pkg.sv @@
package scc_pkg;

    localparam int PAGE_BITS_DEF       = 13;
    localparam int LARGEST_SMALL_BYTES = 262144;

    localparam int SIZE_W    = 32;
    localparam int ALIGNED_W = 33;
    localparam int CLASS_W   = 8;
    localparam int BATCH_W   = 10;
    localparam int PAGES_W   = 21;
    localparam int PROD_W    = BATCH_W + SIZE_W;

    localparam int QUO_BITS  = 9;
    localparam int REM_W     = 19;
    localparam int DIVISOR_W = 18;
    localparam int SHIFTED_W = DIVISOR_W + QUO_BITS;

    localparam logic [BATCH_W-1:0] BATCH_MIN = BATCH_W'(2);
    localparam logic [BATCH_W-1:0] BATCH_MAX = BATCH_W'(512);

    localparam logic [SIZE_W-1:0] DIV_LOW_LIMIT  = SIZE_W'(512);
    localparam logic [SIZE_W-1:0] DIV_HIGH_LIMIT = SIZE_W'(LARGEST_SMALL_BYTES / 2);

    typedef struct packed {
        logic [SIZE_W-1:0]    size;
        logic [ALIGNED_W-1:0] aligned;
        logic [CLASS_W-1:0]   cls;
        logic                 idx_valid;
        logic                 err;
        logic                 clamp_lo;
        logic                 clamp_hi;
        logic [REM_W-1:0]     rem;
        logic [QUO_BITS-1:0]  quo;
    } t_item;

endpackage

@@ rtl/scc_band.sv @@
module scc_band
    import scc_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [SIZE_W-1:0] i_size,
    output logic              o_valid,
    output t_item             o_item
);

    localparam logic [2:0] BAND_TINY  = 3'd0;
    localparam logic [2:0] BAND_SMALL = 3'd1;
    localparam logic [2:0] BAND_MID   = 3'd2;
    localparam logic [2:0] BAND_LARGE = 3'd3;
    localparam logic [2:0] BAND_HUGE  = 3'd4;
    localparam logic [2:0] BAND_PAGE  = 3'd5;

    logic [2:0]           band;
    logic [4:0]           sh;
    logic [REM_W-1:0]     base;
    logic [CLASS_W-1:0]   first;
    logic [ALIGNED_W-1:0] mask;
    logic [REM_W-1:0]     off;
    logic [REM_W:0]       ceil_sum;
    logic [REM_W:0]       ceil_q;
    t_item                n_item;
    logic                 r_valid;
    t_item                r_item;

    always_comb begin
        if (i_size <= SIZE_W'(128)) begin
            band = BAND_TINY;
        end else if (i_size <= SIZE_W'(1024)) begin
            band = BAND_SMALL;
        end else if (i_size <= SIZE_W'(8 * 1024)) begin
            band = BAND_MID;
        end else if (i_size <= SIZE_W'(64 * 1024)) begin
            band = BAND_LARGE;
        end else if (i_size <= SIZE_W'(LARGEST_SMALL_BYTES)) begin
            band = BAND_HUGE;
        end else begin
            band = BAND_PAGE;
        end
    end

    always_comb begin
        case (band)
            BAND_TINY: begin
                sh = 5'd3; base = REM_W'(0); first = CLASS_W'(0);
            end
            BAND_SMALL: begin
                sh = 5'd4; base = REM_W'(128); first = CLASS_W'(16);
            end
            BAND_MID: begin
                sh = 5'd7; base = REM_W'(1024); first = CLASS_W'(72);
            end
            BAND_LARGE: begin
                sh = 5'd10; base = REM_W'(8 * 1024); first = CLASS_W'(128);
            end
            BAND_HUGE: begin
                sh = 5'd13; base = REM_W'(64 * 1024); first = CLASS_W'(184);
            end
            default: begin
                sh = 5'(PAGE_BITS); base = REM_W'(0); first = CLASS_W'(0);
            end
        endcase
    end

    always_comb begin
        mask     = (ALIGNED_W'(1) << sh) - ALIGNED_W'(1);
        off      = i_size[REM_W-1:0] - base;
        ceil_sum = {1'b0, off} + mask[REM_W:0];
        ceil_q   = ceil_sum >> sh;

        n_item           = '0;
        n_item.size      = i_size;
        n_item.err       = (i_size == '0);
        n_item.aligned   = ({1'b0, i_size} + mask) & ~mask;
        n_item.idx_valid = (band != BAND_PAGE) && !n_item.err;
        if (n_item.idx_valid) begin
            n_item.cls = ceil_q[CLASS_W-1:0] - CLASS_W'(1) + first;
        end
        n_item.clamp_hi = (i_size <= DIV_LOW_LIMIT);
        n_item.clamp_lo = (i_size > DIV_HIGH_LIMIT);
        n_item.rem      = REM_W'(LARGEST_SMALL_BYTES);
        n_item.quo      = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/scc_div_stage.sv @@
module scc_div_stage
    import scc_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    logic [SHIFTED_W-1:0] shifted;
    t_item                n_item;
    logic                 r_valid;
    t_item                r_item;

    always_comb begin
        shifted = SHIFTED_W'(i_item.size[DIVISOR_W-1:0]) << BIT;
        n_item  = i_item;
        if (SHIFTED_W'(i_item.rem) >= shifted) begin
            n_item.rem      = i_item.rem - shifted[REM_W-1:0];
            n_item.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/scc_pages.sv @@
module scc_pages
    import scc_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_item                i_item,
    output logic                 o_valid,
    output logic [ALIGNED_W-1:0] o_aligned_size,
    output logic [CLASS_W-1:0]   o_class_index,
    output logic                 o_index_valid,
    output logic [BATCH_W-1:0]   o_batch_count,
    output logic [PAGES_W-1:0]   o_page_count,
    output logic                 o_size_error
);

    logic [BATCH_W-1:0]   batch;
    logic [PROD_W-1:0]    prod;
    logic [PAGES_W-1:0]   pages;

    logic                 r_mul_valid;
    t_item                r_mul_item;
    logic [BATCH_W-1:0]   r_batch;
    logic [PROD_W-1:0]    r_prod;

    logic                 r_out_valid;
    logic [ALIGNED_W-1:0] r_aligned;
    logic [CLASS_W-1:0]   r_cls;
    logic                 r_idx_valid;
    logic [BATCH_W-1:0]   r_batch_out;
    logic [PAGES_W-1:0]   r_pages;
    logic                 r_err;

    always_comb begin
        if (i_item.clamp_lo) begin
            batch = BATCH_MIN;
        end else if (i_item.clamp_hi) begin
            batch = BATCH_MAX;
        end else begin
            batch = BATCH_W'(i_item.quo);
        end
        prod = PROD_W'(batch) * PROD_W'(i_item.size);
    end

    always_comb begin
        pages = r_prod[PAGE_BITS +: PAGES_W];
        if (pages == '0) begin
            pages = PAGES_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_valid <= i_valid;
            r_out_valid <= r_mul_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul_item <= i_item;
        r_batch    <= batch;
        r_prod     <= prod;
        if (r_mul_item.err) begin
            r_aligned   <= '0;
            r_cls       <= '0;
            r_idx_valid <= 1'b0;
            r_batch_out <= '0;
            r_pages     <= '0;
            r_err       <= 1'b1;
        end else begin
            r_aligned   <= r_mul_item.aligned;
            r_cls       <= r_mul_item.cls;
            r_idx_valid <= r_mul_item.idx_valid;
            r_batch_out <= r_batch;
            r_pages     <= pages;
            r_err       <= 1'b0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_aligned_size = r_aligned;
    assign o_class_index  = r_cls;
    assign o_index_valid  = r_idx_valid;
    assign o_batch_count  = r_batch_out;
    assign o_page_count   = r_pages;
    assign o_size_error   = r_err;

endmodule

@@ rtl/size_class_calculator_core.sv @@
// Channel   Ports                                   Handshake
// request   i_request_size                          start high, busy low
// result    o_aligned_size, o_class_index,          o_done for one cycle
//           o_index_valid, o_batch_count,
//           o_page_count, o_size_error
//
// One transaction may start in every cycle; busy is never raised.
// Each result passes through the band decode register, the restoring divider
// (one quotient bit per stage), the batch multiplier register and the
// register for the page shift and output.
// Reset is synchronous and clears only the valid bits of the pipeline.
// The receiver cannot stall, so results leave the pipeline unconditionally.
module size_class_calculator_core
    import scc_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [SIZE_W-1:0]    i_request_size,
    output logic                 o_done,
    output logic [ALIGNED_W-1:0] o_aligned_size,
    output logic [CLASS_W-1:0]   o_class_index,
    output logic                 o_index_valid,
    output logic [BATCH_W-1:0]   o_batch_count,
    output logic [PAGES_W-1:0]   o_page_count,
    output logic                 o_size_error
);

    localparam int LATENCY = QUO_BITS + 3;

    logic  stage_valid [0:QUO_BITS];
    t_item stage_item  [0:QUO_BITS];

    assign busy = 1'b0;

    scc_band #(
        .PAGE_BITS(PAGE_BITS)
    ) u_band (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(start && !busy),
        .i_size (i_request_size),
        .o_valid(stage_valid[0]),
        .o_item (stage_item[0])
    );

    for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
        scc_div_stage #(
            .BIT(QUO_BITS - 1 - g)
        ) u_div_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(stage_valid[g]),
            .i_item (stage_item[g]),
            .o_valid(stage_valid[g+1]),
            .o_item (stage_item[g+1])
        );
    end

    scc_pages #(
        .PAGE_BITS(PAGE_BITS)
    ) u_pages (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (stage_valid[QUO_BITS]),
        .i_item        (stage_item[QUO_BITS]),
        .o_valid       (o_done),
        .o_aligned_size(o_aligned_size),
        .o_class_index (o_class_index),
        .o_index_valid (o_index_valid),
        .o_batch_count (o_batch_count),
        .o_page_count  (o_page_count),
        .o_size_error  (o_size_error)
    );

    // Every accepted transaction yields o_done once it has passed through the whole pipeline.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LATENCY o_done)
        else $error("result did not appear at the pipeline latency");

    a_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_size_error) |-> (!o_index_valid && o_batch_count == '0
            && o_page_count == '0 && o_aligned_size == '0))
        else $error("zero-size result carries non-zero fields");

    a_batch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_size_error) |-> (o_batch_count >= BATCH_MIN
            && o_batch_count <= BATCH_MAX && o_page_count != '0))
        else $error("batch or page count outside its range");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_index_valid) |-> (o_class_index <= CLASS_W'(207)
            && o_aligned_size <= ALIGNED_W'(LARGEST_SMALL_BYTES)))
        else $error("class index or aligned size out of range for a small size");

endmodule
